### rtl/assert_macros.svh
// assertion helpers used by the top-level mapper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define NSFM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition must never be seen at a rising clock edge out of reset
`define NSFM_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### rtl/nsfm_pkg.sv
package nsfm_pkg;

	localparam int CFG_W     = 16;
	localparam int DIM_REG_W = 11;
	localparam int COORD_W   = 10;
	localparam int INDEX_W   = 20;
	localparam int COLOR_W   = 16;

	localparam logic [DIM_REG_W-1:0] RST_SRC_WIDTH  = 11'd320;
	localparam logic [DIM_REG_W-1:0] RST_SRC_HEIGHT = 11'd240;
	localparam logic [DIM_REG_W-1:0] RST_DST_WIDTH  = 11'd320;
	localparam logic [DIM_REG_W-1:0] RST_DST_HEIGHT = 11'd240;

	typedef enum logic [2:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3,
		REG_FIT_MODE   = 3'd4,
		REG_BG_COLOR   = 3'd5
	} nsfm_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] dst_x;
		logic [COORD_W-1:0] dst_y;
	} nsfm_req_t;

	typedef struct packed {
		logic               in_frame;
		logic               use_background;
		logic [COORD_W-1:0] src_col;
		logic [COORD_W-1:0] src_row;
		logic [INDEX_W-1:0] src_index;
		logic [INDEX_W-1:0] dst_index;
		logic [COLOR_W-1:0] fill_color;
	} nsfm_rsp_t;

	// per-pixel flags that ride along with the division lanes
	typedef struct packed {
		logic               in_frame;
		logic               use_background;
		logic [INDEX_W-1:0] dst_index;
	} nsfm_side_t;

	// status of the geometry setup
	typedef struct packed {
		logic ready;
		logic bg_en;
	} nsfm_mode_t;

endpackage

### rtl/nsfm_setup.sv
module nsfm_setup #(
	parameter int MAX_DIM = 1024,
	localparam int DW = $clog2(MAX_DIM + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [nsfm_pkg::CFG_W-1:0]    cfg_data,
	output nsfm_pkg::nsfm_mode_t          mode,
	output logic [DW-1:0]                 sw,
	output logic [DW-1:0]                 sh,
	output logic [DW-1:0]                 dw,
	output logic [DW-1:0]                 dh,
	output logic [nsfm_pkg::COLOR_W-1:0]  color,
	output logic [DW-1:0]                 csub,
	output logic [DW-1:0]                 rsub,
	output logic [DW-1:0]                 hix,
	output logic [DW-1:0]                 hiy,
	output logic [2*DW-1:0]               cadd,
	output logic [2*DW-1:0]               radd,
	output logic [DW-1:0]                 cmul,
	output logic [DW-1:0]                 rmul,
	output logic [DW-1:0]                 cdiv,
	output logic [DW-1:0]                 rdiv
);

	localparam int CNT_W = $clog2(2 * DW);

	typedef enum logic [2:0] {
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_DRAW,
		ST_FIN,
		ST_RUN
	} state_t;

	state_t state_q;

	logic [nsfm_pkg::DIM_REG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic                           fit_q;
	logic [nsfm_pkg::COLOR_W-1:0]   color_q;

	logic [DW-1:0]     sw_q, sh_q, dw_q, dh_q;
	logic              use_h_q;
	logic [2*DW-1:0]   num_q, quo_q;
	logic [DW-1:0]     den_q, rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DW-1:0]     drw_q, drh_q;
	logic [DW-1:0]     csub_q, rsub_q, hix_q, hiy_q, cmul_q, rmul_q, cdiv_q, rdiv_q;
	logic [2*DW-1:0]   cadd_q, radd_q;

	logic [2*DW-1:0] p1, p2;
	logic            use_h_c;
	logic [DW:0]     trial;
	logic            ge;
	logic [DW-1:0]   qn, ox, oy;
	logic            qz;

	function automatic logic [DW-1:0] eff(input logic [nsfm_pkg::DIM_REG_W-1:0] v);
		logic [DW-1:0] r;
		if (v == '0) begin
			r = DW'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = DW'(MAX_DIM);
		end else begin
			r = DW'(v);
		end
		return r;
	endfunction

	assign p1      = (2*DW)'(dw_q) * (2*DW)'(sh_q);
	assign p2      = (2*DW)'(dh_q) * (2*DW)'(sw_q);
	// contain scales by the smaller ratio, cover by the larger
	assign use_h_c = fit_q ? (p1 > p2) : (p1 < p2);
	assign trial   = {rem_q, num_q[2*DW-1]};
	assign ge      = trial >= {1'b0, den_q};
	assign qn      = quo_q[DW-1:0];
	assign qz      = (quo_q == '0);
	assign ox      = (dw_q - drw_q) >> 1;
	assign oy      = (dh_q - drh_q) >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_PREP;
			src_w_q <= nsfm_pkg::RST_SRC_WIDTH;
			src_h_q <= nsfm_pkg::RST_SRC_HEIGHT;
			dst_w_q <= nsfm_pkg::RST_DST_WIDTH;
			dst_h_q <= nsfm_pkg::RST_DST_HEIGHT;
			fit_q   <= 1'b0;
			color_q <= '0;
			sw_q    <= '0;
			sh_q    <= '0;
			dw_q    <= '0;
			dh_q    <= '0;
			use_h_q <= 1'b0;
			num_q   <= '0;
			quo_q   <= '0;
			den_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			drw_q   <= '0;
			drh_q   <= '0;
			csub_q  <= '0;
			rsub_q  <= '0;
			hix_q   <= '0;
			hiy_q   <= '0;
			cadd_q  <= '0;
			radd_q  <= '0;
			cmul_q  <= '0;
			rmul_q  <= '0;
			cdiv_q  <= '0;
			rdiv_q  <= '0;
		end else if (cfg_we) begin
			case (nsfm_pkg::nsfm_reg_t'(cfg_index))
				nsfm_pkg::REG_SRC_WIDTH:  src_w_q <= cfg_data[nsfm_pkg::DIM_REG_W-1:0];
				nsfm_pkg::REG_SRC_HEIGHT: src_h_q <= cfg_data[nsfm_pkg::DIM_REG_W-1:0];
				nsfm_pkg::REG_DST_WIDTH:  dst_w_q <= cfg_data[nsfm_pkg::DIM_REG_W-1:0];
				nsfm_pkg::REG_DST_HEIGHT: dst_h_q <= cfg_data[nsfm_pkg::DIM_REG_W-1:0];
				nsfm_pkg::REG_FIT_MODE:   fit_q   <= cfg_data[0];
				nsfm_pkg::REG_BG_COLOR:   color_q <= cfg_data;
				default: ;
			endcase
			state_q <= ST_PREP;
		end else begin
			case (state_q)
				ST_PREP: begin
					sw_q    <= eff(src_w_q);
					sh_q    <= eff(src_h_q);
					dw_q    <= eff(dst_w_q);
					dh_q    <= eff(dst_h_q);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					use_h_q <= use_h_c;
					num_q   <= use_h_c ? p1 : p2;
					den_q   <= use_h_c ? sw_q : sh_q;
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= CNT_W'(2 * DW - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
					quo_q <= {quo_q[2*DW-2:0], ge};
					num_q <= num_q << 1;
					if (cnt_q == '0) begin
						state_q <= ST_DRAW;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_DRAW: begin
					if (use_h_q) begin
						drw_q <= dw_q;
						drh_q <= qz ? DW'(1) : qn;
					end else begin
						drh_q <= dh_q;
						drw_q <= qz ? DW'(1) : qn;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!fit_q) begin
						csub_q <= ox;
						rsub_q <= oy;
						hix_q  <= ox + drw_q;
						hiy_q  <= oy + drh_q;
						cadd_q <= '0;
						radd_q <= '0;
						cmul_q <= sw_q;
						rmul_q <= sh_q;
						cdiv_q <= drw_q;
						rdiv_q <= drh_q;
					end else if (use_h_q) begin
						// crop top and bottom
						csub_q <= '0;
						rsub_q <= '0;
						hix_q  <= dw_q;
						hiy_q  <= dh_q;
						cadd_q <= '0;
						radd_q <= (quo_q - (2*DW)'(dh_q)) >> 1;
						cmul_q <= sw_q;
						rmul_q <= sw_q;
						cdiv_q <= dw_q;
						rdiv_q <= dw_q;
					end else begin
						// crop left and right
						csub_q <= '0;
						rsub_q <= '0;
						hix_q  <= dw_q;
						hiy_q  <= dh_q;
						cadd_q <= (quo_q - (2*DW)'(dw_q)) >> 1;
						radd_q <= '0;
						cmul_q <= sh_q;
						rmul_q <= sh_q;
						cdiv_q <= dh_q;
						rdiv_q <= dh_q;
					end
					state_q <= ST_RUN;
				end
				ST_RUN: state_q <= ST_RUN;
				default: state_q <= ST_PREP;
			endcase
		end
	end

	assign mode.ready = (state_q == ST_RUN);
	assign mode.bg_en = ~fit_q;
	assign sw    = sw_q;
	assign sh    = sh_q;
	assign dw    = dw_q;
	assign dh    = dh_q;
	assign color = color_q;
	assign csub  = csub_q;
	assign rsub  = rsub_q;
	assign hix   = hix_q;
	assign hiy   = hiy_q;
	assign cadd  = cadd_q;
	assign radd  = radd_q;
	assign cmul  = cmul_q;
	assign rmul  = rmul_q;
	assign cdiv  = cdiv_q;
	assign rdiv  = rdiv_q;

endmodule

### rtl/nsfm_front.sv
module nsfm_front #(
	parameter int MAX_DIM = 1024,
	localparam int DW = $clog2(MAX_DIM + 1),
	localparam int NW = 3 * DW,
	localparam int SIDE_W = $bits(nsfm_pkg::nsfm_side_t),
	localparam int QW = SIDE_W + 2 * NW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nsfm_pkg::nsfm_req_t   req,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  nsfm_pkg::nsfm_mode_t  mode,
	input  logic [DW-1:0]         dw,
	input  logic [DW-1:0]         dh,
	input  logic [DW-1:0]         csub,
	input  logic [DW-1:0]         rsub,
	input  logic [DW-1:0]         hix,
	input  logic [DW-1:0]         hiy,
	input  logic [2*DW-1:0]       cadd,
	input  logic [2*DW-1:0]       radd,
	input  logic [DW-1:0]         cmul,
	input  logic [DW-1:0]         rmul,
	output logic [QW-1:0]         push_data,
	output logic                  push,
	input  logic                  full
);

	localparam int AW = 2 * DW + 1;
	localparam int PW = AW + DW;

	logic                          adv;
	logic                          inf_c, bg_c;
	logic                          v_s1, v_s2;
	logic [nsfm_pkg::COORD_W-1:0]  x_s1, y_s1;
	logic                          inf_s1, bg_s1;
	logic [AW-1:0]                 acol_s1, arow_s1;
	nsfm_pkg::nsfm_side_t          side_s2;
	logic [NW-1:0]                 cnum_s2, rnum_s2;
	logic [PW-1:0]                 cprod, rprod;
	logic [31:0]                   didx;

	// pipeline moves unless the last stage is stuck on a full queue
	assign adv       = ~(v_s2 & full);
	assign req_ready = adv & mode.ready;
	assign push      = v_s2 & ~full;

	assign inf_c = (32'(req.dst_x) < 32'(dw)) && (32'(req.dst_y) < 32'(dh));
	assign bg_c  = mode.bg_en && ((32'(req.dst_x) < 32'(csub)) ||
		(32'(req.dst_x) >= 32'(hix)) || (32'(req.dst_y) < 32'(rsub)) ||
		(32'(req.dst_y) >= 32'(hiy)));

	assign cprod = PW'(acol_s1) * PW'(cmul);
	assign rprod = PW'(arow_s1) * PW'(rmul);
	assign didx  = 32'(y_s1) * 32'(dw) + 32'(x_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid & req_ready;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= req.dst_x;
			y_s1    <= req.dst_y;
			inf_s1  <= inf_c;
			bg_s1   <= inf_c & bg_c;
			acol_s1 <= AW'(req.dst_x) + AW'(cadd) - AW'(csub);
			arow_s1 <= AW'(req.dst_y) + AW'(radd) - AW'(rsub);

			side_s2.in_frame       <= inf_s1;
			side_s2.use_background <= bg_s1;
			side_s2.dst_index      <= inf_s1 ? didx[nsfm_pkg::INDEX_W-1:0] : '0;
			cnum_s2 <= cprod[NW-1:0];
			rnum_s2 <= rprod[NW-1:0];
		end
	end

	assign push_data = {side_s2, cnum_s2, rnum_s2};

endmodule

### rtl/nsfm_queue.sv
module nsfm_queue #(
	parameter int W = 8,
	parameter int DEPTH = 4,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         full,
	output logic         empty
);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

### rtl/nsfm_back.sv
module nsfm_back #(
	parameter int MAX_DIM = 1024,
	localparam int DW = $clog2(MAX_DIM + 1),
	localparam int NW = 3 * DW,
	localparam int SIDE_W = $bits(nsfm_pkg::nsfm_side_t),
	localparam int QW = SIDE_W + 2 * NW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [QW-1:0]                 head,
	input  logic                          empty,
	output logic                          pop,
	input  logic [DW-1:0]                 cdiv,
	input  logic [DW-1:0]                 rdiv,
	input  logic [DW-1:0]                 sw,
	input  logic [DW-1:0]                 sh,
	input  logic [nsfm_pkg::COLOR_W-1:0]  color,
	output nsfm_pkg::nsfm_rsp_t           rsp,
	output logic                          rsp_valid,
	input  logic                          rsp_ready
);

	logic                  adv;
	nsfm_pkg::nsfm_side_t  side_h;
	logic [NW-1:0]         cnum_h, rnum_h;

	logic [DW:0]           vld_s;
	nsfm_pkg::nsfm_side_t  side_s [0:DW];
	logic [NW-1:0]         crem_s [0:DW];
	logic [NW-1:0]         rrem_s [0:DW];
	logic [DW-1:0]         cq_s   [0:DW];
	logic [DW-1:0]         rq_s   [0:DW];
	logic [DW:0]           cov_s, rov_s;

	logic [NW-1:0]         crem_n [1:DW];
	logic [NW-1:0]         rrem_n [1:DW];
	logic [DW-1:0]         cq_n   [1:DW];
	logic [DW-1:0]         rq_n   [1:DW];

	logic                  vld_cl;
	nsfm_pkg::nsfm_side_t  side_cl;
	logic [DW-1:0]         col_cl, row_cl;
	logic                  rsp_valid_q;
	nsfm_pkg::nsfm_rsp_t   rsp_q;
	logic                  src_ok;
	logic [31:0]           sidx;

	assign adv    = ~rsp_valid_q | rsp_ready;
	assign pop    = adv & ~empty;
	assign side_h = head[QW-1 -: SIDE_W];
	assign cnum_h = head[2*NW-1:NW];
	assign rnum_h = head[NW-1:0];

	// one quotient bit per stage, msb first
	always_comb begin
		for (int i = 1; i <= DW; i++) begin
			if (crem_s[i-1] >= (NW'(cdiv) << (DW - i))) begin
				crem_n[i] = crem_s[i-1] - (NW'(cdiv) << (DW - i));
				cq_n[i]   = cq_s[i-1] | (DW'(1) << (DW - i));
			end else begin
				crem_n[i] = crem_s[i-1];
				cq_n[i]   = cq_s[i-1];
			end
			if (rrem_s[i-1] >= (NW'(rdiv) << (DW - i))) begin
				rrem_n[i] = rrem_s[i-1] - (NW'(rdiv) << (DW - i));
				rq_n[i]   = rq_s[i-1] | (DW'(1) << (DW - i));
			end else begin
				rrem_n[i] = rrem_s[i-1];
				rq_n[i]   = rq_s[i-1];
			end
		end
	end

	assign src_ok = side_cl.in_frame & ~side_cl.use_background;
	assign sidx   = 32'(row_cl) * 32'(sw) + 32'(col_cl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			vld_cl      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s       <= {vld_s[DW-1:0], pop};
			vld_cl      <= vld_s[DW];
			rsp_valid_q <= vld_cl;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_h;
			crem_s[0] <= cnum_h;
			rrem_s[0] <= rnum_h;
			cq_s[0]   <= '0;
			rq_s[0]   <= '0;
			// quotient too wide for the lanes is past any edge anyway
			cov_s[0]  <= cnum_h >= (NW'(cdiv) << DW);
			rov_s[0]  <= rnum_h >= (NW'(rdiv) << DW);
			for (int i = 1; i <= DW; i++) begin
				side_s[i] <= side_s[i-1];
				crem_s[i] <= crem_n[i];
				rrem_s[i] <= rrem_n[i];
				cq_s[i]   <= cq_n[i];
				rq_s[i]   <= rq_n[i];
				cov_s[i]  <= cov_s[i-1];
				rov_s[i]  <= rov_s[i-1];
			end

			side_cl <= side_s[DW];
			col_cl  <= (cov_s[DW] || cq_s[DW] >= sw) ? sw - DW'(1) : cq_s[DW];
			row_cl  <= (rov_s[DW] || rq_s[DW] >= sh) ? sh - DW'(1) : rq_s[DW];

			rsp_q.in_frame       <= side_cl.in_frame;
			rsp_q.use_background <= side_cl.use_background;
			rsp_q.src_col        <= src_ok ? nsfm_pkg::COORD_W'(col_cl) : '0;
			rsp_q.src_row        <= src_ok ? nsfm_pkg::COORD_W'(row_cl) : '0;
			rsp_q.src_index      <= src_ok ? sidx[nsfm_pkg::INDEX_W-1:0] : '0;
			rsp_q.dst_index      <= side_cl.dst_index;
			rsp_q.fill_color     <= side_cl.use_background ? color : '0;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

### rtl/nearest_scale_fit_mapper.sv
// a request accepted at one edge passes the front stages, the queue, the two pipelined quotient
// lanes (one bit per stage), a clamp stage and the response register; one response per cycle
// is sustained while requests keep coming and rsp_ready stays high
// after reset and after every register write a geometry setup with a serial divider runs
// (prepare, multiply, divide, draw size, offsets) with req_ready low
// reset is asynchronous, active low; registers return to 320x240 -> 320x240 contain
`include "assert_macros.svh"

module nearest_scale_fit_mapper #(
	parameter int MAX_DIM = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_index,
	input  logic [nsfm_pkg::CFG_W-1:0]   cfg_data,
	input  nsfm_pkg::nsfm_req_t          req,
	input  logic                         req_valid,
	output logic                         req_ready,
	output nsfm_pkg::nsfm_rsp_t          rsp,
	output logic                         rsp_valid,
	input  logic                         rsp_ready
);

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int NW = 3 * DW;
	localparam int QW = $bits(nsfm_pkg::nsfm_side_t) + 2 * NW;
	localparam int QDEPTH = 4;

	nsfm_pkg::nsfm_mode_t          mode;
	logic [DW-1:0]                 sw, sh, dw, dh, csub, rsub, hix, hiy;
	logic [DW-1:0]                 cmul, rmul, cdiv, rdiv;
	logic [2*DW-1:0]               cadd, radd;
	logic [nsfm_pkg::COLOR_W-1:0]  color;
	logic [QW-1:0]                 push_data, head;
	logic                          push, pop, full, empty;

	nsfm_setup #(.MAX_DIM(MAX_DIM)) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mode      (mode),
		.sw        (sw),
		.sh        (sh),
		.dw        (dw),
		.dh        (dh),
		.color     (color),
		.csub      (csub),
		.rsub      (rsub),
		.hix       (hix),
		.hiy       (hiy),
		.cadd      (cadd),
		.radd      (radd),
		.cmul      (cmul),
		.rmul      (rmul),
		.cdiv      (cdiv),
		.rdiv      (rdiv)
	);

	nsfm_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.mode      (mode),
		.dw        (dw),
		.dh        (dh),
		.csub      (csub),
		.rsub      (rsub),
		.hix       (hix),
		.hiy       (hiy),
		.cadd      (cadd),
		.radd      (radd),
		.cmul      (cmul),
		.rmul      (rmul),
		.push_data (push_data),
		.push      (push),
		.full      (full)
	);

	nsfm_queue #(.W(QW), .DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	nsfm_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.cdiv      (cdiv),
		.rdiv      (rdiv),
		.sw        (sw),
		.sh        (sh),
		.color     (color),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

	`NSFM_ASSERT(a_cfg_restarts_setup, cfg_we |=> !req_ready, "request taken during geometry setup")
	`NSFM_ASSERT(a_out_of_frame_zero, rsp_valid && !rsp.in_frame |-> rsp.src_index == 20'd0 && rsp.dst_index == 20'd0 && !rsp.use_background && rsp.fill_color == 16'd0, "out of frame response not cleared")
	`NSFM_ASSERT(a_letterbox_fill, rsp_valid && rsp.use_background |-> rsp.src_col == 10'd0 && rsp.src_row == 10'd0 && rsp.fill_color == color, "letterbox response malformed")
	`NSFM_NEVER(a_cover_no_letterbox, rsp_valid && !mode.bg_en && rsp.use_background, "letterbox flagged in cover mode")

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam logic [2:0] REG_SPARE = 3'd6;
	localparam int DIM_MAX = 1024;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [nsfm_pkg::CFG_W-1:0] cfg_data = '0;
	nsfm_pkg::nsfm_req_t req = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	nsfm_pkg::nsfm_rsp_t rsp;
	logic rsp_valid;
	logic rsp_ready = 1'b0;

	nsfm_pkg::nsfm_req_t pending_reqs[$];
	nsfm_pkg::nsfm_rsp_t expected_pixels[$];
	int mismatches = 0;
	int cycle_count = 0;
	bit req_fired = 1'b0;

	// register copies
	logic [10:0] m_src_w, m_src_h, m_dst_w, m_dst_h;
	logic m_cover;
	logic [15:0] m_bg;

	nearest_scale_fit_mapper i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .req_valid(req_valid), .req_ready(req_ready),
		.rsp(rsp), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready)
	);

	always #1 clk = ~clk;

	function automatic longint unsigned sat_dim(logic [10:0] v);
		if (v < 1) return 1;
		if (v > DIM_MAX) return DIM_MAX;
		return v;
	endfunction

	function automatic longint unsigned clamp_to(longint unsigned v, longint unsigned size);
		return (v >= size) ? size - 1 : v;
	endfunction

	function automatic nsfm_pkg::nsfm_rsp_t map_pixel(nsfm_pkg::nsfm_req_t r);
		longint unsigned sw, sh, dw, dh, x, y, col, row, drw, drh, ox, oy, cy, cx;
		nsfm_pkg::nsfm_rsp_t o;
		bit bg;
		sw = sat_dim(m_src_w);
		sh = sat_dim(m_src_h);
		dw = sat_dim(m_dst_w);
		dh = sat_dim(m_dst_h);
		x = r.dst_x;
		y = r.dst_y;
		col = 0;
		row = 0;
		bg = 1'b0;
		o = '0;
		if (x >= dw || y >= dh) return o;
		if (!m_cover) begin
			if (dw * sh < dh * sw) begin
				drw = dw;
				drh = (sh * dw) / sw;
			end else begin
				drh = dh;
				drw = (sw * dh) / sh;
			end
			if (drw == 0) drw = 1;
			if (drh == 0) drh = 1;
			ox = (dw - drw) / 2;
			oy = (dh - drh) / 2;
			if (x < ox || x >= ox + drw || y < oy || y >= oy + drh) begin
				bg = 1'b1;
			end else begin
				col = clamp_to(((x - ox) * sw) / drw, sw);
				row = clamp_to(((y - oy) * sh) / drh, sh);
			end
		end else if (dw * sh > dh * sw) begin
			cy = ((sh * dw) / sw - dh) / 2;
			row = clamp_to(((y + cy) * sw) / dw, sh);
			col = clamp_to((x * sw) / dw, sw);
		end else begin
			cx = ((sw * dh) / sh - dw) / 2;
			row = clamp_to((y * sh) / dh, sh);
			col = clamp_to(((x + cx) * sh) / dh, sw);
		end
		o.in_frame = 1'b1;
		o.use_background = bg;
		o.src_col = col[9:0];
		o.src_row = row[9:0];
		o.src_index = bg ? '0 : 20'(row * sw + col);
		o.dst_index = 20'(y * dw + x);
		o.fill_color = bg ? m_bg : '0;
		return o;
	endfunction

	function automatic bit idle_now();
		if (cycle_count >= 1000 && cycle_count < 1800) return 1'b0;
		return $urandom_range(99) < 21;
	endfunction

	// request driver, also drives rsp_ready
	always @(negedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && (!req_valid || req_fired)) begin
			if (pending_reqs.size() > 0 && !idle_now()) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
		rsp_ready <= arst_n && !idle_now();
	end

	// accept requests and check responses
	always @(posedge clk) begin
		nsfm_pkg::nsfm_rsp_t want;
		req_fired <= req_valid && req_ready;
		if (req_valid && req_ready) expected_pixels.push_back(map_pixel(req));
		if (rsp_valid && rsp_ready) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %p", rsp);
			end else begin
				want = expected_pixels.pop_front();
				if (rsp.in_frame !== want.in_frame || rsp.use_background !== want.use_background
						|| rsp.src_col !== want.src_col || rsp.src_row !== want.src_row
						|| rsp.src_index !== want.src_index || rsp.dst_index !== want.dst_index
						|| rsp.fill_color !== want.fill_color) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, rsp);
				end
			end
		end
	end

	task automatic cfg_write(logic [2:0] idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		case (idx)
			nsfm_pkg::REG_SRC_WIDTH: m_src_w = val[10:0];
			nsfm_pkg::REG_SRC_HEIGHT: m_src_h = val[10:0];
			nsfm_pkg::REG_DST_WIDTH: m_dst_w = val[10:0];
			nsfm_pkg::REG_DST_HEIGHT: m_dst_h = val[10:0];
			nsfm_pkg::REG_FIT_MODE: m_cover = val[0];
			nsfm_pkg::REG_BG_COLOR: m_bg = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(int sw, int sh, int dw, int dh, int mode, int bg);
		cfg_write(nsfm_pkg::REG_SRC_WIDTH, sw);
		cfg_write(nsfm_pkg::REG_SRC_HEIGHT, sh);
		cfg_write(nsfm_pkg::REG_DST_WIDTH, dw);
		cfg_write(nsfm_pkg::REG_DST_HEIGHT, dh);
		cfg_write(nsfm_pkg::REG_FIT_MODE, mode);
		cfg_write(nsfm_pkg::REG_BG_COLOR, bg);
	endtask

	task automatic push_req(int x, int y);
		nsfm_pkg::nsfm_req_t r;
		r.dst_x = x[9:0];
		r.dst_y = y[9:0];
		pending_reqs.push_back(r);
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || req_valid || expected_pixels.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// mostly in-frame coordinates, some anywhere
	task automatic push_random(int n);
		int dw, dh;
		dw = int'(sat_dim(m_dst_w));
		dh = int'(sat_dim(m_dst_h));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 85)
				push_req($urandom_range(dw - 1), $urandom_range(dh - 1));
			else
				push_req($urandom_range(1023), $urandom_range(1023));
		end
	endtask

	initial begin
		m_src_w = nsfm_pkg::RST_SRC_WIDTH;
		m_src_h = nsfm_pkg::RST_SRC_HEIGHT;
		m_dst_w = nsfm_pkg::RST_DST_WIDTH;
		m_dst_h = nsfm_pkg::RST_DST_HEIGHT;
		m_cover = 1'b0;
		m_bg = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset geometry, corners and out of frame
		push_req(0, 0);
		push_req(319, 239);
		push_req(320, 0);
		push_req(0, 240);
		push_req(1023, 1023);
		drain();
		// letterbox with tall source, then cover
		set_geometry(100, 200, 300, 300, 0, 16'hf81f);
		push_req(0, 0);
		push_req(150, 150);
		push_req(299, 299);
		push_req(75, 10);
		push_req(224, 10);
		drain();
		cfg_write(nsfm_pkg::REG_FIT_MODE, 1);
		cfg_write(REG_SPARE, 16'hffff);
		push_req(0, 0);
		push_req(299, 299);
		push_req(150, 0);
		drain();
		// saturated sizes: zero and above the maximum
		set_geometry(0, 16'hffff, 2047, 0, 0, 16'hffff);
		push_req(0, 0);
		push_req(1023, 0);
		push_req(5, 1);
		drain();
		set_geometry(1024, 1024, 1024, 1024, 1, 16'h0000);
		push_req(1023, 1023);
		push_req(0, 1023);
		push_req(512, 512);
		drain();
		set_geometry(1024, 1, 1, 1024, 0, 16'h07e0);
		push_req(0, 0);
		push_req(0, 512);
		push_req(0, 1023);
		drain();

		for (int p = 0; p < 12; p++) begin
			case (p)
				0: set_geometry(1, 1, 1024, 1024, 1, $urandom);
				1: set_geometry(1024, 1024, 1, 1, 0, $urandom);
				2: set_geometry(1, 1024, 1024, 1, 1, $urandom);
				default: set_geometry($urandom_range(1, 1024), $urandom_range(1, 1024),
					$urandom_range(1, 1024), $urandom_range(1, 1024),
					$urandom_range(1), $urandom);
			endcase
			push_random(42);
			drain();
		end

		if (mismatches == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#400000;
		$display("Verification failed");
		$finish;
	end

endmodule
